[rtl/core/assert_macros.svh]
// assertion macros for the checker file mlps_chk
// no dependencies; the includer supplies clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/mlps_pkg.sv]
// shared constants and types for the multiplexed led pwm scanner
// no dependencies
package mlps_pkg;

  // matrix geometry and pwm resolution
  localparam int ROWS      = 4;
  localparam int CHANNELS  = 6;
  localparam int PWM_STEPS = 128;

  localparam int ENTRY_COUNT = ROWS * CHANNELS;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

  // payload widths fixed by the interface
  localparam int OP_W  = 2;
  localparam int IDX_W = 5;
  localparam int LVL_W = 8;
  localparam int GND_W = 4;
  localparam int DRV_W = 6;

  // how many matrix rows and channels reach the output fields
  localparam int GND_N = (ROWS < GND_W) ? ROWS : GND_W;
  localparam int DRV_N = (CHANNELS < DRV_W) ? CHANNELS : DRV_W;

  // threshold step and the reset value that makes the first tick use zero
  localparam logic [LVL_W-1:0] THR_STEP  = LVL_W'((256 / PWM_STEPS) % 256);
  localparam logic [LVL_W-1:0] THR_RESET = LVL_W'((256 - (256 / PWM_STEPS)) % 256);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

  typedef logic [OP_W-1:0]  op_code_t;
  typedef logic [IDX_W-1:0] entry_idx_t;
  typedef logic [LVL_W-1:0] level_t;
  typedef logic [GND_W-1:0] ground_t;
  typedef logic [DRV_W-1:0] drive_t;

  // request operation codes
  localparam op_code_t OP_TICK   = 2'd0;
  localparam op_code_t OP_WRITE  = 2'd1;
  localparam op_code_t OP_COMMIT = 2'd2;

endpackage

[rtl/core/multiplexed_led_pwm_scanner.sv]
// multiplexed led matrix pwm scanner: double-buffered levels, row scan, threshold compare
// depends on mlps_pkg
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | operation, entry_index, entry_value
//  out_    | output    | out_valid/out_stall | ground_onehot, led_drive
//
// one request per cycle unless in_stall holds back a tick; a tick request's result is registered
// in the output register. the single output register sets the throughput limit.
// writes and commits keep flowing while a tick result is stalled; a new tick
// waits only while the output register is full and stalled.
// reset clears both level buffers, sets the row to the last row and the threshold
// so that the first tick shows row 0 against threshold 0.
module multiplexed_led_pwm_scanner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mlps_pkg::op_code_t    in_operation,
  input  mlps_pkg::entry_idx_t  in_entry_index,
  input  mlps_pkg::level_t      in_entry_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mlps_pkg::ground_t     out_ground_onehot,
  output mlps_pkg::drive_t      out_led_drive
);
  import mlps_pkg::*;

  level_t          back_r  [ENTRY_COUNT];
  level_t          front_r [ROWS][CHANNELS];
  logic [ROW_W-1:0] row_r, row_nxt;
  level_t          thr_r, thr_nxt;

  logic    out_valid_r, out_valid_nxt;
  ground_t out_ground_r, out_ground_nxt;
  drive_t  out_drive_r, out_drive_nxt;

  logic out_busy;
  logic accept;
  logic is_tick, is_write, is_commit;
  logic idx_ok;

  // output register is full and held
  assign out_busy = out_valid_r && out_stall;

  // operation decode
  always_comb begin
    is_tick   = 1'b0;
    is_write  = 1'b0;
    is_commit = 1'b0;
    unique case (in_operation)
      OP_TICK:   is_tick   = 1'b1;
      OP_WRITE:  is_write  = 1'b1;
      OP_COMMIT: is_commit = 1'b1;
      default:   ;
    endcase
  end

  // only a tick needs room in the output register
  assign in_stall = out_busy && is_tick;
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = 32'(in_entry_index) < ENTRY_COUNT;

  // row scan and threshold advance
  always_comb begin
    row_nxt = row_r;
    thr_nxt = thr_r;
    if (is_tick) begin
      if (row_r == ROW_LAST) begin
        row_nxt = '0;
        thr_nxt = thr_r + THR_STEP;
      end else begin
        row_nxt = ROW_W'(row_r + 1'b1);
      end
    end
  end

  // tick result: one-hot row and per-channel compare
  always_comb begin
    out_ground_nxt = '0;
    out_drive_nxt  = '0;
    for (int g = 0; g < GND_N; g++) begin
      out_ground_nxt[g] = (row_nxt == ROW_W'(g));
    end
    for (int k = 0; k < DRV_N; k++) begin
      out_drive_nxt[k] = front_r[row_nxt][k] > thr_nxt;
    end
  end

  // output register loads when empty or drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_busy) begin
      out_valid_nxt = accept && is_tick;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= ROW_LAST;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept && is_tick) begin
        row_r <= row_nxt;
        thr_r <= thr_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && is_tick && !out_busy) begin
      out_ground_r <= out_ground_nxt;
      out_drive_r  <= out_drive_nxt;
    end
  end

  // back buffer writes and commit copy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRY_COUNT; e++) begin
        back_r[e] <= '0;
      end
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          front_r[r][c] <= '0;
        end
      end
    end else if (accept) begin
      if (is_write && idx_ok) begin
        for (int e = 0; e < ENTRY_COUNT; e++) begin
          if (32'(in_entry_index) == e) begin
            back_r[e] <= in_entry_value;
          end
        end
      end
      if (is_commit) begin
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < CHANNELS; c++) begin
            front_r[r][c] <= back_r[r*CHANNELS + c];
          end
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ground_onehot = out_ground_r;
  assign out_led_drive     = out_drive_r;

endmodule

[rtl/core/mlps_chk.sv]
// port-level checker for the led pwm scanner, bound to the top level
// depends on mlps_pkg and assert_macros.svh
`include "assert_macros.svh"

module mlps_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input mlps_pkg::op_code_t    in_operation,
  input logic                  out_valid,
  input logic                  out_stall,
  input mlps_pkg::ground_t     out_ground_onehot
);
  import mlps_pkg::*;

  logic tick_acc;
  logic other_acc;
  logic out_held;

  assign tick_acc  = in_valid && !in_stall && (in_operation == OP_TICK);
  assign other_acc = in_valid && !in_stall && (in_operation != OP_TICK);
  assign out_held  = out_valid && out_stall;

  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, out_held, out_valid)
  // every accepted tick shows a result next cycle
  `CHK_NEXT(a_tick_result, tick_acc, out_valid)
  // writes and commits never create a result
  `CHK_NEXT(a_no_spurious, other_acc && !out_held, !out_valid)
  // input stalls only behind a held result
  `CHK_SAME(a_stall_cause, in_stall, out_held)
  // a valid result always has exactly one active row
  `CHK_SAME(a_row_onehot, out_valid, $onehot(out_ground_onehot))

endmodule

bind multiplexed_led_pwm_scanner mlps_chk u_mlps_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_operation      (in_operation),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ground_onehot (out_ground_onehot)
);
